@@ rtl/ssm9_pkg.sv @@
package ssm9_pkg;

  localparam int NRES  = 9;
  localparam int IDX_W = $clog2(NRES);
  localparam int CNT_W = 30;

  localparam logic [CNT_W-1:0] MODP = 30'd1000000009;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_REPLACE = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_ACC,
    ST_FIN,
    ST_CPY,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_HALF
  } alu_e;

  typedef enum logic {
    PH_ADD,
    PH_REM
  } phase_e;

  function automatic idx_t res_reduce(logic [3:0] r);
    return (r >= 4'(NRES)) ? idx_t'(r - 4'(NRES)) : idx_t'(r);
  endfunction

  // number of rotation terms: NRES / gcd(v, NRES)
  function automatic idx_t run_len(idx_t v);
    idx_t n;
    if (v == '0) begin
      n = idx_t'(1);
    end else if (v == idx_t'(3) || v == idx_t'(6)) begin
      n = idx_t'(3);
    end else begin
      n = idx_t'(NRES);
    end
    return n;
  endfunction

  // (a - v) mod NRES, both below NRES
  function automatic idx_t idx_sub(idx_t a, idx_t v);
    return (a >= v) ? idx_t'(a - v) : idx_t'(a - v + idx_t'(NRES));
  endfunction

endpackage

@@ rtl/subset_sum_mod9_counter_top.sv @@
// Channel   Dir  Bits  Fields (low bit first)
// s_axis    in   16    req_type[1:0], old_residue[5:2], new_residue[9:6], zero pad
// m_axis    out  32    zero_sum_count[29:0], zero pad
//
// One shared modular add/sub/halve unit walks the nine counts, one term per cycle.
// Add: each count plus its rotation by the new residue. Remove: decrement, then d terms per count, d = 1, 3 or 9.
// Replace with distinct residues: remove plus add. Other beats skip the count update.
// s_axis_tready_o is high only while no beat is in work; the output register
// lets one result wait while the next beat is taken and worked.
// Reset clears all counts at once.
module subset_sum_mod9_counter_top import ssm9_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // req_type, old_residue, new_residue
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // zero_sum_count
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   rep_q, rep_d;
  idx_t   v_q, v_d;
  idx_t   newv_q, newv_d;
  idx_t   j_q, j_d;
  idx_t   k_q, k_d;
  idx_t   idx_q, idx_d;
  cnt_t   acc_q, acc_d;
  cnt_t   out_q, out_d;
  logic   out_vld_q, out_vld_d;

  cnt_t   cnt_q [NRES];
  cnt_t   wrk_q [NRES];

  cnt_t   cnt_rd;
  cnt_t   alu_a, alu_b, alu_res;
  alu_e   alu_mode;
  logic   wrk_we, cnt_dec_we, cnt_cpy;

  logic       in_acc;
  logic [1:0] in_req;
  idx_t       in_old, in_new;
  idx_t       k_last;

  logic [CNT_W:0] sum_w, diff_w, red_w;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_req = s_axis_tdata_i[1:0];
  assign in_old = res_reduce(s_axis_tdata_i[5:2]);
  assign in_new = res_reduce(s_axis_tdata_i[9:6]);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

  assign cnt_rd = cnt_q[idx_q];
  assign k_last = (phase_q == PH_ADD) ? idx_t'(1) : idx_t'(run_len(v_q) - idx_t'(1));

  // shared modular unit
  assign sum_w  = {1'b0, alu_a} + {1'b0, alu_b};
  assign diff_w = {1'b0, alu_a} - {1'b0, alu_b};
  assign red_w  = sum_w - {1'b0, MODP};

  always_comb begin
    unique case (alu_mode)
      ALU_ADD:  alu_res = (sum_w >= {1'b0, MODP}) ? red_w[CNT_W-1:0] : sum_w[CNT_W-1:0];
      ALU_SUB:  alu_res = (alu_a >= alu_b) ? diff_w[CNT_W-1:0]
                                           : cnt_t'(diff_w[CNT_W-1:0] + MODP);
      ALU_HALF: alu_res = sum_w[CNT_W:1];
      default:  alu_res = sum_w[CNT_W-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req == REQ_ADD) begin
            state_d = ST_ACC;
          end else if (in_req == REQ_REMOVE ||
                       (in_req == REQ_REPLACE && in_old != in_new)) begin
            state_d = ST_DEC;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DEC: state_d = ST_ACC;
      ST_ACC: begin
        if (k_q == k_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = (j_q == idx_t'(NRES - 1)) ? ST_CPY : ST_ACC;
      ST_CPY: state_d = (phase_q == PH_REM && rep_q) ? ST_ACC : ST_DONE;
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    phase_d    = phase_q;
    rep_d      = rep_q;
    v_d        = v_q;
    newv_d     = newv_q;
    j_d        = j_q;
    k_d        = k_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    alu_a      = acc_q;
    alu_b      = cnt_rd;
    alu_mode   = ALU_ADD;
    wrk_we     = 1'b0;
    cnt_dec_we = 1'b0;
    cnt_cpy    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          newv_d  = in_new;
          rep_d   = (in_req == REQ_REPLACE);
          phase_d = (in_req == REQ_ADD) ? PH_ADD : PH_REM;
          v_d     = (in_req == REQ_ADD) ? in_new : in_old;
          idx_d   = (in_req == REQ_ADD) ? '0 : in_old;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_DEC: begin
        alu_a      = cnt_rd;
        alu_b      = cnt_t'(1);
        alu_mode   = ALU_SUB;
        cnt_dec_we = 1'b1;
        idx_d      = '0;
      end
      ST_ACC: begin
        alu_a    = (k_q == '0) ? '0 : acc_q;
        alu_b    = cnt_rd;
        alu_mode = (phase_q == PH_REM && k_q[0]) ? ALU_SUB : ALU_ADD;
        acc_d    = alu_res;
        idx_d    = idx_sub(idx_q, v_q);
        k_d      = idx_t'(k_q + idx_t'(1));
      end
      ST_FIN: begin
        alu_a = acc_q;
        if (phase_q == PH_REM) begin
          alu_b    = acc_q[0] ? MODP : '0;
          alu_mode = ALU_HALF;
        end else begin
          alu_b    = (j_q == v_q) ? cnt_t'(1) : '0;
          alu_mode = ALU_ADD;
        end
        wrk_we = 1'b1;
        k_d    = '0;
        if (j_q == idx_t'(NRES - 1)) begin
          j_d   = '0;
          idx_d = '0;
        end else begin
          j_d   = idx_t'(j_q + idx_t'(1));
          idx_d = idx_t'(j_q + idx_t'(1));
        end
      end
      ST_CPY: begin
        cnt_cpy = 1'b1;
        if (phase_q == PH_REM && rep_q) begin
          phase_d = PH_ADD;
          rep_d   = 1'b0;
          v_d     = newv_q;
          j_d     = '0;
          k_d     = '0;
          idx_d   = '0;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_d     = cnt_q[0];
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      phase_q   <= PH_ADD;
      rep_q     <= 1'b0;
      j_q       <= '0;
      k_q       <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      phase_q   <= phase_d;
      rep_q     <= rep_d;
      j_q       <= j_d;
      k_q       <= k_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    newv_q <= newv_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
    if (wrk_we) begin
      wrk_q[j_q] <= alu_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NRES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cnt_cpy) begin
      for (int i = 0; i < NRES; i++) begin
        cnt_q[i] <= wrk_q[i];
      end
    end else if (cnt_dec_we) begin
      cnt_q[idx_q] <= alu_res;
    end
  end

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("ready high right after a beat was taken");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> (idx_q < idx_t'(NRES) && j_q < idx_t'(NRES)))
    else $error("count index out of range");

  a_fin_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> alu_res < MODP)
    else $error("unreduced count written");

  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[29:0] < MODP)
    else $error("result not below modulus");

endmodule

@@ bench/ssm9_count_checker.sv @@
module ssm9_count_checker import ssm9_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // req_type, old_residue, new_residue
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // zero_sum_count
  output int          err_cnt_o,
  output int          pending_o
);

  localparam logic [63:0] HALF_INV = 64'd500000005;

  cnt_t tally [NRES];
  cnt_t zero_count_q [$];
  cnt_t want;
  int   result_idx;

  task automatic report_mismatch(string msg);
    $display("checker: result %0d: %s", result_idx, msg);
    err_cnt_o++;
  endtask

  function automatic cnt_t mod_plus(cnt_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODP}) begin
      s = s - {1'b0, MODP};
    end
    return cnt_t'(s);
  endfunction

  function automatic cnt_t mod_minus(cnt_t a, cnt_t b);
    logic [CNT_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, MODP} - {1'b0, b};
    end
    return cnt_t'(s);
  endfunction

  function automatic cnt_t mod_halve(cnt_t a);
    logic [63:0] p;
    p = 64'(a) * HALF_INV;
    return cnt_t'(p % 64'(MODP));
  endfunction

  function automatic void apply_add(int v);
    cnt_t nxt [NRES];
    for (int j = 0; j < NRES; j++) begin
      nxt[j] = mod_plus(tally[j], tally[(j + NRES - v) % NRES]);
    end
    nxt[v] = mod_plus(nxt[v], cnt_t'(1));
    tally = nxt;
  endfunction

  // take one off the removed residue, alternating sum over the rotation orbit, then divide by two
  function automatic void apply_remove(int v);
    cnt_t nxt [NRES];
    cnt_t acc;
    int   a, b, t, terms, idx;
    tally[v] = mod_minus(tally[v], cnt_t'(1));
    a = v;
    b = NRES;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    terms = NRES / a;
    for (int j = 0; j < NRES; j++) begin
      acc = '0;
      idx = j;
      for (int k = 0; k < terms; k++) begin
        acc = (k % 2 == 0) ? mod_plus(acc, tally[idx]) : mod_minus(acc, tally[idx]);
        idx = (idx + NRES - v) % NRES;
      end
      nxt[j] = mod_halve(acc);
    end
    tally = nxt;
  endfunction

  function automatic cnt_t predict_zero_count(logic [15:0] beat);
    int ov, nv;
    ov = int'(beat[5:2]) % NRES;
    nv = int'(beat[9:6]) % NRES;
    case (beat[1:0])
      REQ_ADD: begin
        apply_add(nv);
      end
      REQ_REMOVE: begin
        apply_remove(ov);
      end
      REQ_REPLACE: begin
        if (ov != nv) begin
          apply_remove(ov);
          apply_add(nv);
        end
      end
      default: begin
      end
    endcase
    return tally[0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tally[j]) tally[j] = '0;
      zero_count_q.delete();
      err_cnt_o  = 0;
      result_idx = 0;
      pending_o  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (zero_count_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, count %0d", m_tdata_i[29:0]));
        end else begin
          want = zero_count_q.pop_front();
          if (m_tdata_i[29:0] !== want) begin
            report_mismatch($sformatf("zero_sum_count %0d, want %0d", m_tdata_i[29:0], want));
          end
        end
        result_idx++;
      end
      if (s_tvalid_i && s_tready_i) begin
        zero_count_q = {zero_count_q, predict_zero_count(s_tdata_i)};
      end
      pending_o = zero_count_q.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
module testbench;
  import ssm9_pkg::*;

  localparam logic [1:0] REQ_NONE     = 2'd3;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 150;
  localparam int         PHASE_ITEMS  = 350;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [15:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [31:0] m_data;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int err_cnt;
  int pending;
  int held [NRES];
  int hand_size;

  subset_sum_mod9_counter_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  ssm9_count_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_ready),
    .s_tdata_i  (s_data),
    .m_tvalid_i (m_valid),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_data),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_req(logic [1:0] req, logic [3:0] oldr, logic [3:0] newr);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_valid <= 1'b0;
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= {6'b0, newr, oldr, req};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // sometimes use the out-of-range alias of a residue
  function automatic logic [3:0] alias_res(int r);
    return (r < 16 - NRES && $urandom_range(7) == 0) ? 4'(r + NRES) : 4'(r);
  endfunction

  function automatic int pick_held();
    int r;
    r = $urandom_range(NRES - 1);
    while (held[r] == 0) r = (r + 1) % NRES;
    return r;
  endfunction

  task automatic random_req();
    logic [1:0] req;
    int         ov, nv;
    if ($urandom_range(99) < 20) begin
      send_req(2'($urandom_range(3)), 4'($urandom_range(15)), 4'($urandom_range(15)));
    end else begin
      if (hand_size == 0) begin
        req = REQ_ADD;
      end else if (hand_size > 14) begin
        req = $urandom_range(1) ? REQ_REMOVE : REQ_REPLACE;
      end else begin
        req = 2'($urandom_range(2));
      end
      nv = $urandom_range(NRES - 1);
      ov = (req == REQ_ADD) ? 0 : pick_held();
      case (req)
        REQ_ADD: begin
          send_req(req, 4'($urandom_range(15)), alias_res(nv));
          held[nv]++;
          hand_size++;
        end
        REQ_REMOVE: begin
          send_req(req, alias_res(ov), 4'($urandom_range(15)));
          held[ov]--;
          hand_size--;
        end
        default: begin
          send_req(req, alias_res(ov), alias_res(nv));
          held[ov]--;
          held[nv]++;
        end
      endcase
    end
  endtask

  initial begin
    int send_pct [4] = '{0, 48, 0, 37};
    int recv_pct [4] = '{0, 0, 48, 37};
    rst_n          = 1'b0;
    s_valid        = 1'b0;
    s_data         = '0;
    m_ready        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    hand_size      = 0;
    foreach (held[j]) held[j] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NRES; r++) begin
      send_req(REQ_ADD, (r % 2 == 0) ? 4'hF : 4'h0, 4'(r));
    end
    send_req(REQ_ADD, 4'h0, 4'd9);
    send_req(REQ_ADD, 4'h0, 4'd15);
    send_req(REQ_REMOVE, 4'd0, 4'h0);
    send_req(REQ_REMOVE, 4'd3, 4'hF);
    send_req(REQ_REMOVE, 4'd1, 4'h0);
    send_req(REQ_REMOVE, 4'd1, 4'h0);     // card no longer held
    send_req(REQ_REMOVE, 4'd12, 4'h0);    // aliases an absent card
    send_req(REQ_REPLACE, 4'd4, 4'd4);
    send_req(REQ_REPLACE, 4'd5, 4'd14);
    send_req(REQ_REPLACE, 4'd15, 4'd6);
    send_req(REQ_REPLACE, 4'd0, 4'd8);
    send_req(REQ_REPLACE, 4'd13, 4'd0);
    send_req(REQ_NONE, 4'hF, 4'hF);
    send_req(REQ_NONE, 4'h0, 4'h0);
    send_req(REQ_REMOVE, 4'd7, 4'hF);
    send_req(REQ_ADD, 4'hF, 4'd8);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      repeat (PHASE_ITEMS) random_req();
    end
    @(negedge clk);
    s_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
